// ===== rtl/b58_pkg.sv =====
// Shared constants and alphabet functions for the base58 integer codec.
// No dependencies; every other file imports this package.
package b58_pkg;

   localparam int RADIX       = 58;
   localparam int MAX_SYMBOLS = 11;
   localparam int DIGIT_DEPTH = 11;
   localparam int VALUE_W     = 64;
   localparam int NIB_W       = 4;
   localparam int DIGIT_W     = 6;
   localparam int SYM_W       = 8;
   localparam int CNT_W       = 4;
   localparam int IDX_W       = $clog2(DIGIT_DEPTH);
   localparam int STEPS       = VALUE_W / NIB_W;
   localparam int STEP_W      = $clog2(STEPS);
   localparam int PROD_W      = 10;

   localparam logic [0:0] MODE_ENCODE = 1'b0;
   localparam logic [0:0] MODE_DECODE = 1'b1;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [SYM_W-1:0]   sym_type;

   typedef struct packed {
      logic      valid;
      digit_type digit;
   } dec_digit_type;

   // Map a digit value 0..57 to its ASCII symbol.
   function automatic sym_type sym_of(input digit_type d);
      sym_type dv;
      sym_type s;
      dv = SYM_W'(d);
      if (dv < 8'd9)       s = 8'h31 + dv;
      else if (dv < 8'd17) s = 8'h41 + dv - 8'd9;
      else if (dv < 8'd22) s = 8'h4A + dv - 8'd17;
      else if (dv < 8'd33) s = 8'h50 + dv - 8'd22;
      else if (dv < 8'd44) s = 8'h61 + dv - 8'd33;
      else                 s = 8'h6D + dv - 8'd44;
      return s;
   endfunction

   // Map an ASCII symbol to its digit value; valid is low outside the alphabet.
   function automatic dec_digit_type digit_of(input sym_type c);
      dec_digit_type r;
      sym_type       v;
      r.valid = 1'b1;
      v       = '0;
      if (c >= 8'h31 && c <= 8'h39)      v = c - 8'h31;
      else if (c >= 8'h41 && c <= 8'h48) v = c - 8'h41 + 8'd9;
      else if (c >= 8'h4A && c <= 8'h4E) v = c - 8'h4A + 8'd17;
      else if (c >= 8'h50 && c <= 8'h5A) v = c - 8'h50 + 8'd22;
      else if (c >= 8'h61 && c <= 8'h6B) v = c - 8'h61 + 8'd33;
      else if (c >= 8'h6D && c <= 8'h7A) v = c - 8'h6D + 8'd44;
      else                               r.valid = 1'b0;
      r.digit = v[DIGIT_W-1:0];
      return r;
   endfunction

endpackage

// ===== rtl/b58_if.sv =====
// Valid/ready channel interfaces for the base58 codec request and response.
// Depends on b58_pkg for field widths.
interface b58_req_if import b58_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [VALUE_W-1:0]   number;
   logic [SYM_W-1:0]     symbol;
   logic                 final_symbol;

   modport source (output valid, mode, number, symbol, final_symbol, input ready);
   modport sink   (input valid, mode, number, symbol, final_symbol, output ready);
endinterface

interface b58_rsp_if import b58_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SYM_W-1:0]     symbol_out;
   logic [VALUE_W-1:0]   value_out;
   logic                 ok;
   logic                 run_end;

   modport source (output valid, symbol_out, value_out, ok, run_end, input ready);
   modport sink   (input valid, symbol_out, value_out, ok, run_end, output ready);
endinterface

// ===== rtl/base58_codec_u64.sv =====
// Base58 codec for 64-bit unsigned integers. Encode finds each base58 digit
// with a nibble-serial divide by 58 that walks the 64-bit value four bits a
// cycle, then sends one symbol per cycle while the response register is not
// held; a zero value skips the divide. The response register lets the last
// symbol wait while a new transaction is taken. Decode runs a nibble-serial
// multiply-by-58 of the accumulator for each symbol; a bad or excess symbol
// skips the multiply. The final symbol then passes through S_RES, which loads
// the result into the response register.
// Depends on b58_pkg, b58_if and b58_div_nib.
module base58_codec_u64 import b58_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   b58_req_if.sink    req,
   b58_rsp_if.source  rsp
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_EMIT = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_RES  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                derr_ff, derr_in;
   logic                last_ff, last_in;
   logic                resdec_ff, resdec_in;
   logic [VALUE_W-1:0]  rem_ff, rem_in;
   logic [DIGIT_W-1:0]  rmd_ff, rmd_in;
   logic [DIGIT_W-1:0]  car_ff, car_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [IDX_W-1:0]    ndig_ff, ndig_in;
   logic [IDX_W-1:0]    emit_ff, emit_in;
   digit_type           dbuf_ff [DIGIT_DEPTH];
   logic                dbuf_we;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]    sym_ff, sym_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic                ok_ff, ok_in;
   logic                end_ff, end_in;

   logic [NIB_W-1:0]    quo_nib;
   logic [DIGIT_W-1:0]  rmd_nxt;
   logic [PROD_W-1:0]   prod;
   dec_digit_type       dd;
   logic [CNT_W-1:0]    cnt_inc;
   logic                err_new;
   logic                slot_free;
   logic                accept;

   b58_div_nib u_div (
      .rmd_i (rmd_ff),
      .nib_i (rem_ff[VALUE_W-1 -: NIB_W]),
      .quo_o (quo_nib),
      .rmd_o (rmd_nxt)
   );

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp.ready;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.symbol_out = sym_ff;
   assign rsp.value_out  = val_ff;
   assign rsp.ok         = ok_ff;
   assign rsp.run_end    = end_ff;

   // Nibble-serial accumulator multiply: carry absorbs the new digit up front.
   assign prod    = PROD_W'(acc_ff[NIB_W-1:0]) * PROD_W'(RADIX) + PROD_W'(car_ff);
   assign dd      = digit_of(req.symbol);
   assign cnt_inc = (cnt_ff == {CNT_W{1'b1}}) ? cnt_ff : cnt_ff + 1'b1;
   assign err_new = derr_ff || (cnt_inc > CNT_W'(MAX_SYMBOLS)) || !dd.valid;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      derr_in      = derr_ff;
      last_in      = last_ff;
      resdec_in    = resdec_ff;
      rem_in       = rem_ff;
      rmd_in       = rmd_ff;
      car_in       = car_ff;
      step_in      = step_ff;
      ndig_in      = ndig_ff;
      emit_in      = emit_ff;
      dbuf_we      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      sym_in       = sym_ff;
      val_in       = val_ff;
      ok_in        = ok_ff;
      end_in       = end_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req.mode == MODE_ENCODE) begin
                  resdec_in = 1'b0;
                  rem_in    = req.number;
                  rmd_in    = '0;
                  step_in   = '0;
                  ndig_in   = '0;
                  state_in  = (req.number == '0) ? S_RES : S_DIV;
               end else begin
                  resdec_in = 1'b1;
                  cnt_in    = cnt_inc;
                  derr_in   = err_new;
                  last_in   = req.final_symbol;
                  car_in    = dd.digit;
                  step_in   = '0;
                  if (!err_new) begin
                     state_in = S_MUL;
                  end else if (req.final_symbol) begin
                     state_in = S_RES;
                  end
               end
            end
         end
         S_DIV: begin
            rem_in  = {rem_ff[VALUE_W-NIB_W-1:0], quo_nib};
            rmd_in  = rmd_nxt;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               dbuf_we = 1'b1;
               ndig_in = ndig_ff + 1'b1;
               rmd_in  = '0;
               if (rem_in == '0) begin
                  emit_in  = ndig_ff;
                  state_in = S_EMIT;
               end else if (ndig_ff == IDX_W'(MAX_SYMBOLS - 1)) begin
                  // value needs more digits than allowed
                  state_in = S_RES;
               end
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               sym_in       = sym_of(dbuf_ff[emit_ff]);
               val_in       = '0;
               ok_in        = 1'b1;
               end_in       = (emit_ff == '0);
               emit_in      = emit_ff - 1'b1;
               if (emit_ff == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MUL: begin
            acc_in  = {prod[NIB_W-1:0], acc_ff[VALUE_W-1:NIB_W]};
            car_in  = prod[PROD_W-1:NIB_W];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               // carry out of the top nibble means the value overflowed
               if (prod[PROD_W-1:NIB_W] != '0) begin
                  derr_in = 1'b1;
               end
               state_in = last_ff ? S_RES : S_IDLE;
            end
         end
         S_RES: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               sym_in       = '0;
               end_in       = 1'b1;
               if (resdec_ff) begin
                  ok_in   = !derr_ff;
                  val_in  = derr_ff ? '0 : acc_ff;
                  acc_in  = '0;
                  cnt_in  = '0;
                  derr_in = 1'b0;
               end else begin
                  ok_in   = 1'b0;
                  val_in  = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         derr_ff      <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         derr_ff      <= derr_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff   <= last_in;
      resdec_ff <= resdec_in;
      rmd_ff    <= rmd_in;
      car_ff    <= car_in;
      step_ff   <= step_in;
      ndig_ff   <= ndig_in;
      emit_ff   <= emit_in;
      sym_ff    <= sym_in;
      val_ff    <= val_in;
      ok_ff     <= ok_in;
      end_ff    <= end_in;
      if (dbuf_we) begin
         dbuf_ff[ndig_ff] <= rmd_nxt;
      end
   end

endmodule

// ===== rtl/b58_div_nib.sv =====
// Four steps of restoring division by 58: folds one dividend nibble into the
// running remainder and yields four quotient bits. Depends on b58_pkg.
module b58_div_nib import b58_pkg::*; (
   input  logic [DIGIT_W-1:0] rmd_i,
   input  logic [NIB_W-1:0]   nib_i,
   output logic [NIB_W-1:0]   quo_o,
   output logic [DIGIT_W-1:0] rmd_o
);

   always_comb begin
      logic [DIGIT_W:0] r;
      r     = {1'b0, rmd_i};
      quo_o = '0;
      for (int i = NIB_W - 1; i >= 0; i--) begin
         r = {r[DIGIT_W-1:0], nib_i[i]};
         if (r >= (DIGIT_W+1)'(RADIX)) begin
            r        = r - (DIGIT_W+1)'(RADIX);
            quo_o[i] = 1'b1;
         end
      end
      rmd_o = r[DIGIT_W-1:0];
   end

endmodule
